// ===== rtl/core/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and codes of the tick timer task table
// Beat formats, command classes and result kinds used by the front end, the
// executor and the top level.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int unsigned NumSlotsDef = 16;
  localparam int unsigned IdWidthDef  = 16;

  // Opcodes of the input beat
  localparam logic [1:0] OPC_TICK   = 2'd0;
  localparam logic [1:0] OPC_ADD    = 2'd1;
  localparam logic [1:0] OPC_CANCEL = 2'd2;
  localparam logic [1:0] OPC_CLEAR  = 2'd3;

  // Result kinds
  localparam logic [2:0] K_FIRED     = 3'd0;
  localparam logic [2:0] K_ADDED     = 3'd1;
  localparam logic [2:0] K_FULL      = 3'd2;
  localparam logic [2:0] K_CANCELLED = 3'd3;
  localparam logic [2:0] K_NOTFOUND  = 3'd4;
  localparam logic [2:0] K_CLEARED   = 3'd5;
  localparam logic [2:0] K_TICKDONE  = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        first_delay;
    logic [31:0]        repeat_interval;
    logic signed [15:0] repeat_count;
    logic [15:0]        cancel_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic        last;
  } out_t;

  // Command class decided by the front end
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_CANCEL,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    in_t  item;
  } entry_t;

  // Queue head handed from front end to executor
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== rtl/core/ttt_front.sv =====
// ----------------------------------------------------------------------------
// ttt_front: command intake
// Accepts command beats, classifies the opcode and holds them in a two-entry
// queue that the executor drains.
// ----------------------------------------------------------------------------
module ttt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ttt_pkg::in_t   cmd_i,
  output ttt_pkg::head_t head_o,
  input  logic           pop_i
);

  ttt_pkg::entry_t mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  ttt_pkg::entry_t new_entry;

  // Classify the opcode
  always_comb begin
    new_entry.item = cmd_i;
    case (cmd_i.opcode)
      ttt_pkg::OPC_TICK:   new_entry.cmd = ttt_pkg::CMD_TICK;
      ttt_pkg::OPC_ADD:    new_entry.cmd = ttt_pkg::CMD_ADD;
      ttt_pkg::OPC_CANCEL: new_entry.cmd = ttt_pkg::CMD_CANCEL;
      default:             new_entry.cmd = ttt_pkg::CMD_CLEAR;
    endcase
  end

  assign busy   = (cnt_q == 2'd2);
  assign push   = start && !busy;
  assign head_o = '{valid: (cnt_q != 2'd0), entry: mem_q[rptr_q]};

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= new_entry;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/core/ttt_exec.sv =====
// ----------------------------------------------------------------------------
// ttt_exec: slot table executor
// Holds the timer slots and runs one queued command at a time. A tick scans
// each slot once, firing those at zero, then fires the newly due lowest first.
// ----------------------------------------------------------------------------
module ttt_exec #(
  parameter int unsigned NUM_SLOTS = ttt_pkg::NumSlotsDef,
  parameter int unsigned ID_WIDTH  = ttt_pkg::IdWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttt_pkg::head_t head_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output ttt_pkg::out_t  res_o
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIRE
  } state_e;

  state_e                 state_q, state_d;
  logic [SW-1:0]          idx_q, idx_d;
  logic [NUM_SLOTS-1:0]   due_q, due_d;
  logic [NUM_SLOTS-1:0]   valid_q, valid_d;
  logic [ID_WIDTH-1:0]    nid_q, nid_d;
  ttt_pkg::out_t          res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  logic [31:0]            rem_q [NUM_SLOTS];
  logic [31:0]            ivl_q [NUM_SLOTS];
  logic signed [15:0]     cnt_q [NUM_SLOTS];
  logic [ID_WIDTH-1:0]    id_q  [NUM_SLOTS];

  logic                   free_found;
  logic [SW-1:0]          free_idx, due_idx, ra, wa;
  logic [NUM_SLOTS-1:0]   hit;
  logic [ID_WIDTH-1:0]    cid;
  logic [31:0]            rd_rem, rd_ivl, reload, rem_wd;
  logic signed [15:0]     rd_cnt, cnt_dec, cnt_wd;
  logic [ID_WIDTH-1:0]    rd_id;
  logic                   alive, add_we, rem_we, cnt_we;
  ttt_pkg::entry_t        hd;

  assign hd  = head_i.entry;
  assign cid = ID_WIDTH'(hd.item.cancel_id);

  // Lowest free slot, lowest due slot, cancel matches
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    due_idx    = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
      if (due_q[i]) begin
        due_idx = SW'(i);
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i] = valid_q[i] && (id_q[i] == cid);
    end
  end

  // Single read port of the slot table and the reload rule
  assign ra      = (state_q == S_FIRE) ? due_idx : idx_q;
  assign rd_rem  = rem_q[ra];
  assign rd_ivl  = ivl_q[ra];
  assign rd_cnt  = cnt_q[ra];
  assign rd_id   = id_q[ra];
  assign reload  = (rd_ivl == 32'd0) ? 32'd1 : rd_ivl;
  assign alive   = (rd_cnt != 16'sd0);
  assign cnt_dec = rd_cnt[15] ? rd_cnt : rd_cnt - 16'sd1;

  // Sequence the commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    due_d       = due_q;
    valid_d     = valid_q;
    nid_d       = nid_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    pop_o       = 1'b0;
    add_we      = 1'b0;
    rem_we      = 1'b0;
    cnt_we      = 1'b0;
    rem_wd      = reload;
    cnt_wd      = cnt_dec;
    wa          = ra;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o       = 1'b1;
          res_valid_d = (hd.cmd != ttt_pkg::CMD_TICK);
          res_d.last  = 1'b1;
          case (hd.cmd)
            ttt_pkg::CMD_ADD: begin
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                add_we            = 1'b1;
                wa                = free_idx;
                res_d.kind        = ttt_pkg::K_ADDED;
                res_d.task_id     = 16'(nid_q);
                nid_d             = nid_q + 1'b1;
              end else begin
                res_d.kind = ttt_pkg::K_FULL;
              end
            end
            ttt_pkg::CMD_CANCEL: begin
              valid_d = valid_q & ~hit;
              if (hit != '0) begin
                res_d.kind    = ttt_pkg::K_CANCELLED;
                res_d.task_id = 16'(cid);
              end else begin
                res_d.kind = ttt_pkg::K_NOTFOUND;
              end
            end
            ttt_pkg::CMD_CLEAR: begin
              valid_d    = '0;
              res_d.kind = ttt_pkg::K_CLEARED;
            end
            default: begin
              idx_d   = '0;
              due_d   = '0;
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (valid_q[idx_q]) begin
          if (rd_rem == 32'd0) begin
            // already at zero: fire now, ahead of the late ones
            res_valid_d   = 1'b1;
            res_d.kind    = ttt_pkg::K_FIRED;
            res_d.task_id = 16'(rd_id);
            rem_we        = alive;
            cnt_we        = alive;
            if (!alive) begin
              valid_d[idx_q] = 1'b0;
            end
          end else begin
            rem_we = 1'b1;
            rem_wd = rd_rem - 32'd1;
            if (rd_rem == 32'd1) begin
              due_d[idx_q] = 1'b1;
            end
          end
        end
        if (idx_q == SW'(NUM_SLOTS - 1)) begin
          state_d = S_FIRE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIRE: begin
        res_valid_d = 1'b1;
        if (due_q != '0) begin
          res_d.kind       = ttt_pkg::K_FIRED;
          res_d.task_id    = 16'(rd_id);
          due_d[due_idx]   = 1'b0;
          rem_we           = alive;
          cnt_we           = alive;
          if (!alive) begin
            valid_d[due_idx] = 1'b0;
          end
        end else begin
          res_d.kind = ttt_pkg::K_TICKDONE;
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      due_q       <= '0;
      valid_q     <= '0;
      nid_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      due_q       <= due_d;
      valid_q     <= valid_d;
      nid_q       <= nid_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Slot fields
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      rem_q[wa] <= hd.item.first_delay;
      ivl_q[wa] <= hd.item.repeat_interval;
      cnt_q[wa] <= hd.item.repeat_count;
      id_q[wa]  <= nid_q;
    end else begin
      if (rem_we) begin
        rem_q[wa] <= rem_wd;
      end
      if (cnt_we) begin
        cnt_q[wa] <= cnt_wd;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_nonlast_is_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> res_q.kind == ttt_pkg::K_FIRED)
    else $error("non-final result is not a firing");

  a_single_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && hd.cmd != ttt_pkg::CMD_TICK |=> res_valid_q && res_q.last)
    else $error("single-beat command gave no final result");

  a_idle_no_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> due_q == '0)
    else $error("due slots left over after a tick");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !pop_o)
    else $error("queue popped while a tick is in progress");
`endif

endmodule

// ===== rtl/core/tick_timer_task_table.sv =====
// ----------------------------------------------------------------------------
// tick_timer_task_table: table of periodic timer slots
// Top level: command intake queue feeding the slot table executor.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; a two-entry
// queue lets up to two commands wait while the executor works. Add, cancel and
// clear each answer with one result beat; the command is queued and its result
// is registered, and a tick in progress holds it back. A tick walks the slot
// table once, one slot per cycle, firing any already at zero, then fires
// the newly due one per cycle, ending with the tick done beat. Each result is
// on res_o for one cycle, marked by res_valid_o, and must be taken then.
module tick_timer_task_table #(
  parameter int unsigned NUM_SLOTS = ttt_pkg::NumSlotsDef,
  parameter int unsigned ID_WIDTH  = ttt_pkg::IdWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ttt_pkg::in_t  cmd_i,
  output logic          res_valid_o,
  output ttt_pkg::out_t res_o
);

  ttt_pkg::head_t head;
  logic           pop;

  ttt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .head_o (head),
    .pop_i  (pop)
  );

  ttt_exec #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_WIDTH  (ID_WIDTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
